// ===== rtl/coulomb_friction_force_core_macros.svh =====
// assertion macros shared by the coulomb friction force modules
`ifndef COULOMB_FRICTION_FORCE_CORE_MACROS_SVH
`define COULOMB_FRICTION_FORCE_CORE_MACROS_SVH

// same-cycle implication
`define CFF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cff_pkg.sv =====
// types, constants and helpers shared by the coulomb friction force modules
`default_nettype none
package cff_pkg;

  localparam int unsigned MU_W       = 20;
  localparam int unsigned MASS_W     = 31;
  localparam int unsigned Q_W        = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned SQ_W       = 2 * Q_W;
  localparam int unsigned G_W        = 20;
  localparam int unsigned WPROD_W    = MASS_W + G_W;
  localparam int unsigned WT_W       = WPROD_W - FRAC_W;
  localparam int unsigned WT_HI_W    = WT_W - Q_W;
  localparam int unsigned LSF_W      = MU_W + WT_W;
  localparam int unsigned LIM_W      = LSF_W - FRAC_W;
  localparam int unsigned LIM_HI_W   = LIM_W - Q_W;
  localparam int unsigned ROOT_W     = Q_W + 1;
  localparam int unsigned PROD_W     = LIM_W + Q_W;
  localparam int unsigned SQ_STG     = Q_W;
  localparam int unsigned DIV_STG    = LIM_W;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [G_W-1:0]     G_Q16    = 20'd642253;
  localparam logic [WPROD_W-1:0] RND_HALF = WPROD_W'(32'h0000_8000);
  localparam logic [Q_W-1:0]     SAT_POS  = 32'h7fff_ffff;
  localparam logic [Q_W-1:0]     SAT_NEG  = 32'h8000_0000;

  typedef enum logic [1:0] {
    REG_REST    = 2'd0,
    REG_HOLD    = 2'd1,
    REG_KINETIC = 2'd2,
    REG_CLAMPED = 2'd3
  } regime_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATIC_MU  = 1'b0,
    CFG_KINETIC_MU = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [MASS_W-1:0]     mass;
    logic signed [Q_W-1:0] force_x;
    logic signed [Q_W-1:0] force_y;
    logic signed [Q_W-1:0] force_z;
    logic signed [Q_W-1:0] vel_x;
    logic signed [Q_W-1:0] vel_y;
    logic signed [Q_W-1:0] vel_z;
  } cff_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] fric_x;
    logic signed [Q_W-1:0] fric_z;
    logic [1:0]            regime;
  } cff_out_t;

  // classified request handed from front to back
  typedef struct packed {
    regime_t               regime;
    logic                  dir_zero;
    logic signed [Q_W-1:0] fx;
    logic signed [Q_W-1:0] fz;
    logic                  neg_x;
    logic                  neg_z;
    logic [Q_W-1:0]        abs_vx;
    logic [Q_W-1:0]        abs_vz;
    logic [SQ_W-1:0]       f2;
    logic [SQ_W-1:0]       v2;
    logic [LIM_W-1:0]      mk;
  } cff_job_t;

  function automatic logic [Q_W-1:0] abs32(logic [Q_W-1:0] v);
    return v[Q_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cff_front.sv =====
// front: config registers, weight, limits and squared norms, regime classification
`default_nettype none
module cff_front import cff_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MU_W-1:0]      cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cff_in_t              in_data,
  output logic                 job_push,
  output cff_job_t             job,
  input  logic                 job_space
);

  typedef struct packed {
    logic signed [Q_W-1:0] fx;
    logic signed [Q_W-1:0] fz;
    logic signed [Q_W-1:0] vx;
    logic signed [Q_W-1:0] vz;
  } fwd_t;

  localparam int unsigned FR_STG = 6;

  logic [MU_W-1:0]   static_mu_r;
  logic [MU_W-1:0]   kinetic_mu_r;
  logic              en;
  logic [FR_STG-1:0] vld_r;

  cff_in_t              s1_r;
  fwd_t                 s2_fw_r, s3_fw_r, s4_fw_r, s5_fw_r, s6_fw_r;
  logic [SQ_W-1:0]      s2_sfx_r, s2_sfy_r, s2_sfz_r, s2_svx_r, s2_svy_r, s2_svz_r;
  logic [WPROD_W-1:0]   s2_wprod_r;
  logic [SQ_W-1:0]      s3_f2_r, s3_v2_r, s4_f2_r, s4_v2_r, s5_f2_r, s5_v2_r;
  logic [SQ_W-1:0]      s6_f2_r, s6_v2_r;
  logic [WT_W-1:0]      s3_wt_r;
  logic [MU_W+Q_W-1:0]  s4_ls_lo_r, s4_mk_lo_r;
  logic [MU_W+WT_HI_W-1:0] s4_ls_hi_r, s4_mk_hi_r;
  logic [LIM_W-1:0]     s5_ls_r, s5_mk_r, s6_mk_r;
  logic                 s6_ls_big_r, s6_mk_big_r;
  logic [SQ_W-1:0]      s6_ls_sq_r, s6_mk_sq_r;

  logic [WPROD_W-1:0]   wsum;
  logic [LSF_W-1:0]     ls_full, mk_full;
  logic                 v2z, f2z, static_ex, kin_ex;
  regime_t              rg;

  function automatic logic [SQ_W-1:0] sq32(logic [Q_W-1:0] a);
    return SQ_W'(a) * SQ_W'(a);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      static_mu_r  <= '0;
      kinetic_mu_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STATIC_MU:  static_mu_r  <= cfg_wdata;
        CFG_KINETIC_MU: kinetic_mu_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = job_space;
  assign in_ready = en;
  assign job_push = vld_r[FR_STG-1] && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[FR_STG-2:0], in_valid};
    end
  end

  assign wsum    = s2_wprod_r + RND_HALF;
  assign ls_full = {s4_ls_hi_r, {Q_W{1'b0}}} + LSF_W'(s4_ls_lo_r);
  assign mk_full = {s4_mk_hi_r, {Q_W{1'b0}}} + LSF_W'(s4_mk_lo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r       <= in_data;
      s2_sfx_r   <= sq32(abs32(s1_r.force_x));
      s2_sfy_r   <= sq32(abs32(s1_r.force_y));
      s2_sfz_r   <= sq32(abs32(s1_r.force_z));
      s2_svx_r   <= sq32(abs32(s1_r.vel_x));
      s2_svy_r   <= sq32(abs32(s1_r.vel_y));
      s2_svz_r   <= sq32(abs32(s1_r.vel_z));
      s2_wprod_r <= WPROD_W'(s1_r.mass) * WPROD_W'(G_Q16);
      s2_fw_r    <= '{fx: s1_r.force_x, fz: s1_r.force_z, vx: s1_r.vel_x, vz: s1_r.vel_z};
      s3_f2_r    <= s2_sfx_r + s2_sfy_r + s2_sfz_r;
      s3_v2_r    <= s2_svx_r + s2_svy_r + s2_svz_r;
      s3_wt_r    <= wsum[WPROD_W-1:FRAC_W];
      s3_fw_r    <= s2_fw_r;
      s4_ls_lo_r <= (MU_W+Q_W)'(static_mu_r) * (MU_W+Q_W)'(s3_wt_r[Q_W-1:0]);
      s4_ls_hi_r <= (MU_W+WT_HI_W)'(static_mu_r) * (MU_W+WT_HI_W)'(s3_wt_r[WT_W-1:Q_W]);
      s4_mk_lo_r <= (MU_W+Q_W)'(kinetic_mu_r) * (MU_W+Q_W)'(s3_wt_r[Q_W-1:0]);
      s4_mk_hi_r <= (MU_W+WT_HI_W)'(kinetic_mu_r) * (MU_W+WT_HI_W)'(s3_wt_r[WT_W-1:Q_W]);
      s4_f2_r    <= s3_f2_r;
      s4_v2_r    <= s3_v2_r;
      s4_fw_r    <= s3_fw_r;
      s5_ls_r    <= ls_full[LSF_W-1:FRAC_W];
      s5_mk_r    <= mk_full[LSF_W-1:FRAC_W];
      s5_f2_r    <= s4_f2_r;
      s5_v2_r    <= s4_v2_r;
      s5_fw_r    <= s4_fw_r;
      s6_ls_big_r <= |s5_ls_r[LIM_W-1:Q_W];
      s6_mk_big_r <= |s5_mk_r[LIM_W-1:Q_W];
      s6_ls_sq_r <= sq32(s5_ls_r[Q_W-1:0]);
      s6_mk_sq_r <= sq32(s5_mk_r[Q_W-1:0]);
      s6_mk_r    <= s5_mk_r;
      s6_f2_r    <= s5_f2_r;
      s6_v2_r    <= s5_v2_r;
      s6_fw_r    <= s5_fw_r;
    end
  end

  always_comb begin
    v2z       = (s6_v2_r == '0);
    f2z       = (s6_f2_r == '0);
    static_ex = s6_ls_big_r || (s6_ls_sq_r > s6_f2_r);
    kin_ex    = s6_mk_big_r || (s6_mk_sq_r > s6_f2_r);
    if (v2z && f2z) begin
      rg = REG_REST;
    end else if (v2z && static_ex) begin
      rg = REG_HOLD;
    end else if (kin_ex) begin
      rg = REG_CLAMPED;
    end else begin
      rg = REG_KINETIC;
    end
    job.regime   = rg;
    job.dir_zero = v2z;
    job.fx       = s6_fw_r.fx;
    job.fz       = s6_fw_r.fz;
    job.neg_x    = !s6_fw_r.vx[Q_W-1] && (s6_fw_r.vx != '0);
    job.neg_z    = !s6_fw_r.vz[Q_W-1] && (s6_fw_r.vz != '0);
    job.abs_vx   = abs32(s6_fw_r.vx);
    job.abs_vz   = abs32(s6_fw_r.vz);
    job.f2       = s6_f2_r;
    job.v2       = s6_v2_r;
    job.mk       = s6_mk_r;
  end

endmodule
`default_nettype wire

// ===== rtl/cff_fifo.sv =====
// short request queue between the classifying front and the arithmetic back
`default_nettype none
`include "coulomb_friction_force_core_macros.svh"
module cff_fifo import cff_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  cff_job_t push_data,
  output logic     space,
  input  logic     pop,
  output logic     nonempty,
  output cff_job_t pop_data
);

  cff_job_t           mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_CW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rp_r];
  assign space    = cnt_r < FIFO_CW'(FIFO_DEPTH);
  assign nonempty = cnt_r != '0;

  `CFF_ASSERT_IMP(a_no_overflow, clk, rst_n, push, cnt_r != FIFO_CW'(FIFO_DEPTH), "queue written while full")
  `CFF_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, cnt_r != '0, "queue read while empty")
  `CFF_ASSERT_NXT(a_count_up, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "queue count lost a request")

endmodule
`default_nettype wire

// ===== rtl/cff_back.sv =====
// back: square roots, scaled direction, long division, saturation and output register
`default_nettype none
`include "coulomb_friction_force_core_macros.svh"
module cff_back import cff_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_valid,
  input  cff_job_t job,
  output logic     job_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output cff_out_t out_data
);

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] root;
  } sqs_t;

  typedef struct packed {
    logic [ROOT_W-1:0] r;
    logic [LIM_W-1:0]  lo;
    logic [LIM_W-1:0]  q;
  } dvs_t;

  typedef struct packed {
    regime_t               regime;
    logic                  dir_zero;
    logic signed [Q_W-1:0] fx;
    logic signed [Q_W-1:0] fz;
    logic                  neg_x;
    logic                  neg_z;
  } meta_t;

  localparam int unsigned BK_STG = SQ_STG + DIV_STG + 3;
  localparam logic [SQ_W-1:0] SQ_ONE = SQ_W'(1);

  logic              adv;
  logic [BK_STG-1:0] v_r;
  logic              out_vld_r;
  cff_out_t          out_data_r;

  cff_job_t sj_r  [SQ_STG+1];
  sqs_t     sqf_r [SQ_STG+1];
  sqs_t     sqv_r [SQ_STG+1];

  meta_t                 m1_meta_r;
  logic [SQ_W-1:0]       m1_xlo_r, m1_zlo_r;
  logic [LIM_W-1:0]      m1_xhi_r, m1_zhi_r;
  logic [ROOT_W-1:0]     m1_vl_r;

  meta_t                 dm_r  [DIV_STG+1];
  dvs_t                  dx_r  [DIV_STG+1];
  dvs_t                  dz_r  [DIV_STG+1];
  logic [ROOT_W-1:0]     dvl_r [DIV_STG+1];

  cff_job_t              sq_end;
  logic [LIM_W-1:0]      m_sel;
  logic [PROD_W-1:0]     prod_x, prod_z;
  meta_t                 md;
  logic [Q_W-1:0]        ox, oz;

  function automatic sqs_t sqrt_step(sqs_t s, logic [SQ_W-1:0] b);
    logic [SQ_W:0] trial;
    sqs_t o;
    trial = {1'b0, s.root} + {1'b0, b};
    if ({1'b0, s.n} >= trial) begin
      o.n    = s.n - trial[SQ_W-1:0];
      o.root = (s.root >> 1) + b;
    end else begin
      o.n    = s.n;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  function automatic dvs_t div_step(dvs_t d, logic [ROOT_W-1:0] dv);
    logic [ROOT_W:0] t;
    dvs_t o;
    t    = {d.r, d.lo[LIM_W-1]};
    o.lo = d.lo << 1;
    if (t >= {1'b0, dv}) begin
      o.r = ROOT_W'(t - {1'b0, dv});
      o.q = {d.q[LIM_W-2:0], 1'b1};
    end else begin
      o.r = t[ROOT_W-1:0];
      o.q = {d.q[LIM_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [Q_W-1:0] sat_mag(logic neg, logic [LIM_W-1:0] mag);
    logic [Q_W-1:0] r;
    if (neg) begin
      r = (mag >= LIM_W'(SAT_NEG)) ? SAT_NEG : ({Q_W{1'b0}} - mag[Q_W-1:0]);
    end else begin
      r = (mag >= LIM_W'(SAT_POS)) ? SAT_POS : mag[Q_W-1:0];
    end
    return r;
  endfunction

  assign adv     = !out_vld_r || out_ready;
  assign job_pop = adv && job_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      v_r       <= {v_r[BK_STG-2:0], job_pop};
      out_vld_r <= v_r[BK_STG-1];
    end
  end

  // square root pipeline, one result bit per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      sj_r[0]  <= job;
      sqf_r[0] <= '{n: job.f2, root: '0};
      sqv_r[0] <= '{n: job.v2, root: '0};
      for (int k = 0; k < SQ_STG; k++) begin
        sj_r[k+1]  <= sj_r[k];
        sqf_r[k+1] <= sqrt_step(sqf_r[k], SQ_ONE << (SQ_W - 2 - 2 * k));
        sqv_r[k+1] <= sqrt_step(sqv_r[k], SQ_ONE << (SQ_W - 2 - 2 * k));
      end
    end
  end

  assign sq_end = sj_r[SQ_STG];
  assign m_sel  = (sq_end.regime == REG_CLAMPED) ?
                  LIM_W'(sqf_r[SQ_STG].root[ROOT_W-1:0]) : sq_end.mk;

  // magnitude times direction component, split partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_meta_r <= '{regime: sq_end.regime, dir_zero: sq_end.dir_zero, fx: sq_end.fx,
                     fz: sq_end.fz, neg_x: sq_end.neg_x, neg_z: sq_end.neg_z};
      m1_xlo_r  <= SQ_W'(m_sel[Q_W-1:0]) * SQ_W'(sq_end.abs_vx);
      m1_zlo_r  <= SQ_W'(m_sel[Q_W-1:0]) * SQ_W'(sq_end.abs_vz);
      m1_xhi_r  <= LIM_W'(m_sel[LIM_W-1:Q_W]) * LIM_W'(sq_end.abs_vx);
      m1_zhi_r  <= LIM_W'(m_sel[LIM_W-1:Q_W]) * LIM_W'(sq_end.abs_vz);
      m1_vl_r   <= sqv_r[SQ_STG].root[ROOT_W-1:0];
    end
  end

  assign prod_x = {m1_xhi_r, {Q_W{1'b0}}} + PROD_W'(m1_xlo_r);
  assign prod_z = {m1_zhi_r, {Q_W{1'b0}}} + PROD_W'(m1_zlo_r);

  // restoring division by the velocity norm, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      dm_r[0]  <= m1_meta_r;
      dvl_r[0] <= m1_vl_r;
      dx_r[0]  <= '{r: ROOT_W'(prod_x[PROD_W-1:LIM_W]), lo: prod_x[LIM_W-1:0], q: '0};
      dz_r[0]  <= '{r: ROOT_W'(prod_z[PROD_W-1:LIM_W]), lo: prod_z[LIM_W-1:0], q: '0};
      for (int j = 0; j < DIV_STG; j++) begin
        dm_r[j+1]  <= dm_r[j];
        dvl_r[j+1] <= dvl_r[j];
        dx_r[j+1]  <= div_step(dx_r[j], dvl_r[j]);
        dz_r[j+1]  <= div_step(dz_r[j], dvl_r[j]);
      end
    end
  end

  always_comb begin
    md = dm_r[DIV_STG];
    case (md.regime)
      REG_REST: begin
        ox = '0;
        oz = '0;
      end
      REG_HOLD: begin
        ox = sat_mag(!md.fx[Q_W-1] && (md.fx != '0), LIM_W'(abs32(md.fx)));
        oz = sat_mag(!md.fz[Q_W-1] && (md.fz != '0), LIM_W'(abs32(md.fz)));
      end
      default: begin
        ox = md.dir_zero ? '0 : sat_mag(md.neg_x, dx_r[DIV_STG].q);
        oz = md.dir_zero ? '0 : sat_mag(md.neg_z, dz_r[DIV_STG].q);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.fric_x <= ox;
      out_data_r.fric_z <= oz;
      out_data_r.regime <= md.regime;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  `CFF_ASSERT_IMP(a_rest_zero, clk, rst_n, out_vld_r && out_data_r.regime == REG_REST, out_data_r.fric_x == '0 && out_data_r.fric_z == '0, "resting result not zero")

endmodule
`default_nettype wire

// ===== rtl/coulomb_friction_force_core.sv =====
// coulomb ground friction core: top level
//
// in_valid/in_ready/in_data carries one body request (mass, force and velocity,
// Q16.16); out_valid/out_ready/out_data returns fric_x, fric_z and the regime.
// cfg_we/cfg_index/cfg_wdata writes static_mu (index 0) or kinetic_mu (index 1);
// write only while no request is in flight. Throughput is one request per
// cycle when out_ready does not stall. An accepted request passes through
// the classification stages, the queue, 32 square root stages, 2 multiply
// stages, 39 division stages and the output register on its way to out_valid.
// A stalled receiver freezes the back pipeline as a whole; the 4-entry queue
// then fills and in_ready drops until results drain again. in_ready never
// depends on out_ready in the same cycle.
// Synchronous active-low reset empties the pipelines and the queue and clears
// both coefficients to zero; no request is in flight afterwards.
`default_nettype none
module coulomb_friction_force_core import cff_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MU_W-1:0]      cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cff_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cff_out_t             out_data
);

  logic     q_push, q_space, q_pop, q_nonempty;
  cff_job_t q_in, q_out;

  cff_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_push  (q_push),
    .job       (q_in),
    .job_space (q_space)
  );

  cff_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .space     (q_space),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_data  (q_out)
  );

  cff_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_nonempty),
    .job       (q_out),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the coulomb friction force core: table-driven and random checks
`default_nettype none
module tb_top;
  import cff_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_STATIC_MU;
  logic [MU_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  cff_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cff_out_t out_data;

  always #1 clk = ~clk;

  coulomb_friction_force_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  logic [MU_W-1:0] static_coef = '0;
  logic [MU_W-1:0] kinetic_coef = '0;
  cff_out_t friction_q[$];
  int errors = 0;
  int send_idle = 18;
  int recv_idle = 67;

  typedef struct {
    cff_in_t req;
    logic typed;
    cff_out_t res;
  } row_t;

  task automatic report(string what, cff_out_t got, cff_out_t want);
    $display("mismatch %s: got %h %h %0d want %h %h %0d", what, got.fric_x, got.fric_z,
             got.regime, want.fric_x, want.fric_z, want.regime);
    errors++;
  endtask

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] clip(logic neg, logic [127:0] mag);
    if (neg) return (mag >= 128'h8000_0000) ? SAT_NEG : 32'(-mag);
    return (mag >= 128'h7fff_ffff) ? SAT_POS : mag[31:0];
  endfunction

  function automatic cff_out_t friction(cff_in_t r);
    cff_out_t o;
    logic [127:0] w, ls, mk, f2, v2, vlen, ax, az;
    logic signed [63:0] fx, fy, fz, vx, vy, vz;
    fx = r.force_x; fy = r.force_y; fz = r.force_z;
    vx = r.vel_x; vy = r.vel_y; vz = r.vel_z;
    w = (128'(r.mass) * 642253 + 32768) >> 16;
    f2 = 128'(fx * fx) + 128'(fy * fy) + 128'(fz * fz);
    v2 = 128'(vx * vx) + 128'(vy * vy) + 128'(vz * vz);
    ls = (128'(static_coef) * w) >> 16;
    o = '0;
    if (v2 == 0 && f2 == 0) return o;
    if (v2 == 0 && ls * ls > f2) begin
      o.fric_x = clip(fx > 0, 128'(fx < 0 ? -fx : fx));
      o.fric_z = clip(fz > 0, 128'(fz < 0 ? -fz : fz));
      o.regime = REG_HOLD;
      return o;
    end
    mk = (128'(kinetic_coef) * w) >> 16;
    o.regime = REG_KINETIC;
    if (mk * mk > f2) begin
      mk = 128'(root64(f2[63:0]));
      o.regime = REG_CLAMPED;
    end
    if (v2 == 0) return o;
    vlen = 128'(root64(v2[63:0]));
    ax = 128'(vx < 0 ? -vx : vx);
    az = 128'(vz < 0 ? -vz : vz);
    o.fric_x = clip(vx > 0, mk * ax / vlen);
    o.fric_z = clip(vz > 0, mk * az / vlen);
    return o;
  endfunction

  task automatic write_coef(cfg_idx_t idx, logic [MU_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_STATIC_MU) static_coef = val;
    else kinetic_coef = val;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (friction_q.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  task automatic send(cff_in_t r, logic typed, cff_out_t res);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    friction_q.push_back(typed ? res : friction(r));
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] rnd_q();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 0;
      3: return 32'($signed($urandom_range(40000)) - 20000) <<< 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic cff_in_t rnd_req();
    cff_in_t r;
    r.mass = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(1 << 22));
    r.force_x = rnd_q(); r.force_y = rnd_q(); r.force_z = rnd_q();
    if ($urandom_range(3) == 0) begin
      r.vel_x = 0; r.vel_y = 0; r.vel_z = 0;
    end else begin
      r.vel_x = rnd_q(); r.vel_y = rnd_q(); r.vel_z = rnd_q();
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (friction_q.size() == 0) begin
        report("unexpected result", out_data, '0);
      end else begin
        if (out_data.fric_x !== friction_q[0].fric_x) report("fric_x", out_data, friction_q[0]);
        if (out_data.fric_z !== friction_q[0].fric_z) report("fric_z", out_data, friction_q[0]);
        if (out_data.regime !== friction_q[0].regime) report("regime", out_data, friction_q[0]);
        void'(friction_q.pop_front());
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t t;
    int mus[4] = '{0, 655360, 1048575, 65536};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // coefficients zero after reset
    t.typed = 1'b1;
    t.req = '0;
    t.res = '0; rows.push_back(t);
    t.req.mass = 31'h7fff_ffff; t.req.force_x = 32'h8000_0000;
    t.res.fric_x = 0; t.res.fric_z = 0; t.res.regime = REG_KINETIC; rows.push_back(t);
    t.req = '0; t.req.mass = 31'h7fff_ffff;
    t.res = '0; rows.push_back(t);
    foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].res);
    drain();
    rows.delete();
    t.typed = 1'b0;
    t.req = '0; t.req.mass = 31'h7fff_ffff; t.req.force_x = 32'h8000_0000;
    rows.push_back(t);
    t.req.force_z = 32'h7fff_ffff; t.req.force_y = 32'h8000_0000; rows.push_back(t);
    t.req.mass = 31'h1_0000; t.req.force_x = 32'h5_0000; rows.push_back(t);
    t.req.vel_x = 32'h8000_0000; t.req.vel_z = 32'h7fff_ffff; rows.push_back(t);
    t.req.vel_x = 0; t.req.vel_z = 0; t.req.vel_y = 32'h1; rows.push_back(t);
    t.req.force_x = 0; t.req.force_y = 0; t.req.force_z = 0; rows.push_back(t);
    t.req.vel_x = 32'hffff_ffff; t.req.mass = 0; rows.push_back(t);
    t.req = '0; t.req.mass = 31'h7fff_ffff; t.req.vel_x = 32'h10000; rows.push_back(t);
    t.req.force_x = 32'h0000_0001; rows.push_back(t);
    foreach (mus[p]) begin
      write_coef(CFG_STATIC_MU, MU_W'(mus[p]));
      write_coef(CFG_KINETIC_MU, MU_W'(mus[(p + 1) % 4]));
      foreach (rows[i]) send(rows[i].req, 1'b0, rows[i].res);
      drain();
    end
    for (int n = 0; n < 800; n++) begin
      if (n == 300) begin
        send_idle = 67; recv_idle = 18;
      end
      if (n == 600) begin
        send_idle = 0; recv_idle = 0;
      end
      if (n % 100 == 50) begin
        drain();
        write_coef(CFG_STATIC_MU, ($urandom_range(4) == 0) ? 20'hfffff : 20'($urandom_range(655360)));
        write_coef(CFG_KINETIC_MU, ($urandom_range(4) == 0) ? 20'd0 : 20'($urandom_range(655360)));
      end
      send(rnd_req(), 1'b0, '0);
    end
    drain();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
